@@ design/srtf_pkg.sv @@
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Shared types and codes for the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int STAT_W = 3;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_RAN      = 3'd2;
    localparam logic [STAT_W-1:0] ST_FINISHED = 3'd3;
    localparam logic [STAT_W-1:0] ST_IDLE     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADMIT,
        S_RUN,
        S_REINS,
        S_OUT
    } state_t;

    // Command broadcast to every cell in a chain.
    typedef struct packed {
        logic              ins;   // sorted insert of key/id/aux
        logic              pop;   // remove the head, shift toward it
        logic [TIME_W-1:0] key;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] aux;
    } chain_cmd_t;

endpackage

@@ design/srtf_job_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// SRTF job scheduler top level
// Preemptive shortest-remaining-time-first scheduler built on two sorted
// chains of cells: one ordered by arrival time, one by remaining time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_* carries a command (add job or tick) with job fields.
//   Result channel m_* returns one result per command: status, run_id,
//   tick_time and remaining.
//   An add does its chain work in the accepting cycle and its result is
//   offered in the next. A tick first admits the jobs that have arrived by
//   that tick, with one sorted insert into the ready chain each, then runs the
//   head job and, when it is not finished, reinserts it into the ready chain
//   before its result is offered.
//   One command is processed at a time. While a result waits because m_ready
//   is low, s_ready stays low. After reset both chains are empty and the time
//   counter is all ones, so the first tick reports time zero.
// ----------------------------------------------------------------------------
module srtf_job_scheduler_top
    import srtf_pkg::*;
#(
    parameter int MAX_JOBS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [ID_W-1:0]   s_job_id,
    input  logic [TIME_W-1:0] s_arrival_time,
    input  logic [TIME_W-1:0] s_need_time,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [ID_W-1:0]   m_run_id,
    output logic [TIME_W-1:0] m_tick_time,
    output logic [TIME_W-1:0] m_remaining
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic [TIME_W-1:0] rem_reg, rem_next;

    chain_cmd_t        arr_cmd, rdy_cmd;
    logic              arr_hv, rdy_hv;
    logic [TIME_W-1:0] arr_hk, rdy_hk, arr_ha, rdy_ha;
    logic [ID_W-1:0]   arr_hi, rdy_hi;
    logic [TIME_W-1:0] rem_dec;

    srtf_chain #(.DEPTH(MAX_JOBS)) u_arr (
        .aclk(aclk), .aresetn(aresetn), .cmd(arr_cmd),
        .head_valid(arr_hv), .head_key(arr_hk), .head_id(arr_hi), .head_aux(arr_ha)
    );

    srtf_chain #(.DEPTH(MAX_JOBS)) u_rdy (
        .aclk(aclk), .aresetn(aresetn), .cmd(rdy_cmd),
        .head_valid(rdy_hv), .head_key(rdy_hk), .head_id(rdy_hi), .head_aux(rdy_ha)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = (state_reg == S_OUT);
    assign m_status    = stat_reg;
    assign m_run_id    = rid_reg;
    // Add results report a tick time of zero.
    assign m_tick_time = (stat_reg == ST_ADDED || stat_reg == ST_FULL) ? '0 : time_reg;
    assign m_remaining = rem_reg;
    assign rem_dec     = rdy_hk - TIME_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            time_reg  <= '1;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            time_reg  <= time_next;
        end
    end

    always_ff @(posedge aclk) begin
        stat_reg <= stat_next;
        rid_reg  <= rid_next;
        rem_reg  <= rem_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        time_next  = time_reg;
        stat_next  = stat_reg;
        rid_next   = rid_reg;
        rem_next   = rem_reg;
        arr_cmd    = '0;
        rdy_cmd    = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_ADD) begin
                        rid_next  = '0;
                        rem_next  = '0;
                        state_next = S_OUT;
                        if (count_reg >= CNT_W'(MAX_JOBS)) begin
                            stat_next = ST_FULL;
                        end else begin
                            stat_next   = ST_ADDED;
                            count_next  = count_reg + CNT_W'(1);
                            arr_cmd.ins = 1'b1;
                            arr_cmd.key = s_arrival_time;
                            arr_cmd.id  = s_job_id;
                            arr_cmd.aux = (s_need_time == '0) ? TIME_W'(1) : s_need_time;
                        end
                    end else begin
                        time_next  = time_reg + TIME_W'(1);
                        state_next = S_ADMIT;
                    end
                end
            end
            // Move one arrived job per cycle into the ready chain.
            S_ADMIT: begin
                if (arr_hv && (arr_hk <= time_reg)) begin
                    arr_cmd.pop = 1'b1;
                    rdy_cmd.ins = 1'b1;
                    rdy_cmd.key = arr_ha;
                    rdy_cmd.id  = arr_hi;
                end else begin
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (!rdy_hv) begin
                    stat_next  = ST_IDLE;
                    rid_next   = '0;
                    rem_next   = '0;
                    state_next = S_OUT;
                end else begin
                    rdy_cmd.pop = 1'b1;
                    rid_next    = rdy_hi;
                    rem_next    = rem_dec;
                    if (rem_dec == '0) begin
                        stat_next  = ST_FINISHED;
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_OUT;
                    end else begin
                        stat_next  = ST_RAN;
                        state_next = S_REINS;
                    end
                end
            end
            S_REINS: begin
                rdy_cmd.ins = 1'b1;
                rdy_cmd.key = rem_reg;
                rdy_cmd.id  = rid_reg;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic unused_aux;
    assign unused_aux = ^rdy_ha;

    ap_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_JOBS))
        else $error("job count exceeds capacity");

    ap_full_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_ADD && count_reg == CNT_W'(MAX_JOBS))
        |=> (count_reg == $past(count_reg)))
        else $error("rejected add changed job count");

    ap_idle_no_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_IDLE) |-> (m_run_id == '0))
        else $error("idle tick reports a job");

    ap_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rdy_cmd.ins && rdy_cmd.pop))
        else $error("ready chain insert and pop together");

endmodule

@@ design/srtf_cell.sv @@
// ----------------------------------------------------------------------------
// SRTF sorted-queue cell
// One slot of a sorted chain. On insert, a cell whose key is greater than the
// new key (or that is empty) takes the new entry or its left neighbor's entry.
// On pop, every cell takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module srtf_cell
    import srtf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  chain_cmd_t        cmd,
    // left neighbor (toward head)
    input  logic              left_valid,
    input  logic              left_move,
    input  logic [TIME_W-1:0] left_key,
    input  logic [ID_W-1:0]   left_id,
    input  logic [TIME_W-1:0] left_aux,
    // right neighbor (toward tail)
    input  logic              right_valid,
    input  logic [TIME_W-1:0] right_key,
    input  logic [ID_W-1:0]   right_id,
    input  logic [TIME_W-1:0] right_aux,
    output logic              valid,
    output logic              move,
    output logic [TIME_W-1:0] key,
    output logic [ID_W-1:0]   id,
    output logic [TIME_W-1:0] aux
);

    logic              valid_reg;
    logic [TIME_W-1:0] key_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] aux_reg;

    // This cell's entry moves right when the new key sorts before it.
    assign move  = valid_reg && (key_reg > cmd.key);
    assign valid = valid_reg;
    assign key   = key_reg;
    assign id    = id_reg;
    assign aux   = aux_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.pop) begin
            valid_reg <= right_valid;
        end else if (cmd.ins) begin
            valid_reg <= valid_reg || left_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop) begin
            key_reg <= right_key;
            id_reg  <= right_id;
            aux_reg <= right_aux;
        end else if (cmd.ins && (move || !valid_reg)) begin
            if (left_move) begin
                key_reg <= left_key;
                id_reg  <= left_id;
                aux_reg <= left_aux;
            end else if (left_valid || !valid_reg) begin
                key_reg <= cmd.key;
                id_reg  <= cmd.id;
                aux_reg <= cmd.aux;
            end
        end
    end

endmodule

@@ design/srtf_chain.sv @@
// ----------------------------------------------------------------------------
// SRTF sorted chain
// A row of cells forming a queue sorted by key, stable for equal keys.
// ----------------------------------------------------------------------------
module srtf_chain
    import srtf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  chain_cmd_t        cmd,
    output logic              head_valid,
    output logic [TIME_W-1:0] head_key,
    output logic [ID_W-1:0]   head_id,
    output logic [TIME_W-1:0] head_aux
);

    logic              v   [DEPTH+1];
    logic              mv  [DEPTH];
    logic [TIME_W-1:0] k   [DEPTH+1];
    logic [ID_W-1:0]   i   [DEPTH+1];
    logic [TIME_W-1:0] a   [DEPTH+1];

    // Sentinels: left of head is a valid non-moving entry, right of tail empty.
    assign v[DEPTH]  = 1'b0;
    assign k[DEPTH]  = '0;
    assign i[DEPTH]  = '0;
    assign a[DEPTH]  = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic              lv;
            logic              lm;
            logic [TIME_W-1:0] lk;
            logic [ID_W-1:0]   li;
            logic [TIME_W-1:0] la;
            if (g == 0) begin : g_head
                assign lv = 1'b1;
                assign lm = 1'b0;
                assign lk = '0;
                assign li = '0;
                assign la = '0;
            end else begin : g_body
                assign lv = v[g-1];
                assign lm = mv[g-1];
                assign lk = k[g-1];
                assign li = i[g-1];
                assign la = a[g-1];
            end
            srtf_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .left_valid  (lv),
                .left_move   (lm),
                .left_key    (lk),
                .left_id     (li),
                .left_aux    (la),
                .right_valid (v[g+1]),
                .right_key   (k[g+1]),
                .right_id    (i[g+1]),
                .right_aux   (a[g+1]),
                .valid       (v[g]),
                .move        (mv[g]),
                .key         (k[g]),
                .id          (i[g]),
                .aux         (a[g])
            );
        end
    endgenerate

    assign head_valid = v[0];
    assign head_key   = k[0];
    assign head_id    = i[0];
    assign head_aux   = a[0];

endmodule

@@ dv/srtf_job_scheduler_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SRTF job scheduler testbench
// Drives add and tick commands through the valid/ready input channel, predicts
// each result with a behavioral scheduler and compares every result transfer
// field by field. A directed table comes first, then random job streams under
// several idling phases.
// ----------------------------------------------------------------------------
module srtf_job_scheduler_top_test;
    import srtf_pkg::*;

    localparam int JOBS = 16;

    typedef struct {
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] need;
        bit                has_exp;
        logic [STAT_W-1:0] e_status;
        logic [TIME_W-1:0] e_time;
    } row_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   run_id;
        logic [TIME_W-1:0] tick_time;
        logic [TIME_W-1:0] remaining;
    } sched_res_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_command = CMD_ADD;
    logic [ID_W-1:0]   s_job_id = '0;
    logic [TIME_W-1:0] s_arrival_time = '0;
    logic [TIME_W-1:0] s_need_time = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [ID_W-1:0]   m_run_id;
    logic [TIME_W-1:0] m_tick_time;
    logic [TIME_W-1:0] m_remaining;

    // Scheduler shadow state.
    logic [ID_W-1:0]   pend_id[$];
    logic [TIME_W-1:0] pend_arr[$];
    logic [TIME_W-1:0] pend_need[$];
    logic [ID_W-1:0]   rdy_id[$];
    logic [TIME_W-1:0] rdy_rem[$];
    logic [TIME_W-1:0] now_time;

    sched_res_t expected_results[$];
    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    row_t dir_rows[$];
    row_t typed_rows[$];

    always #10 aclk = ~aclk;

    srtf_job_scheduler_top #(.MAX_JOBS(JOBS)) u_top (.*);

    function automatic void ready_insert(input logic [ID_W-1:0] id,
                                         input logic [TIME_W-1:0] rem);
        int pos;
        pos = 0;
        while (pos < rdy_rem.size() && rdy_rem[pos] <= rem) pos++;
        rdy_id.insert(pos, id);
        rdy_rem.insert(pos, rem);
    endfunction

    function automatic sched_res_t predict_schedule(input logic cmd, input logic [ID_W-1:0] id,
                                                    input logic [TIME_W-1:0] arr,
                                                    input logic [TIME_W-1:0] need);
        sched_res_t r;
        int pos;
        logic [ID_W-1:0] rid;
        logic [TIME_W-1:0] rem;
        r = '{ST_ADDED, '0, '0, '0};
        if (cmd == CMD_ADD) begin
            if (pend_id.size() + rdy_id.size() >= JOBS) begin
                r.status = ST_FULL;
                return r;
            end
            if (need == 0) need = 1;
            pos = 0;
            while (pos < pend_arr.size() && pend_arr[pos] <= arr) pos++;
            pend_id.insert(pos, id);
            pend_arr.insert(pos, arr);
            pend_need.insert(pos, need);
            return r;
        end
        now_time = now_time + 1'b1;
        while (pend_arr.size() > 0 && pend_arr[0] <= now_time) begin
            ready_insert(pend_id[0], pend_need[0]);
            void'(pend_id.pop_front());
            void'(pend_arr.pop_front());
            void'(pend_need.pop_front());
        end
        r.tick_time = now_time;
        if (rdy_id.size() == 0) begin
            r.status = ST_IDLE;
            return r;
        end
        rid = rdy_id.pop_front();
        rem = rdy_rem.pop_front();
        rem = rem - 1'b1;
        r.run_id = rid;
        r.remaining = rem;
        if (rem == 0) begin
            r.status = ST_FINISHED;
        end else begin
            r.status = ST_RAN;
            ready_insert(rid, rem);
        end
        return r;
    endfunction

    // Valid stays high after a transfer only when the next item follows at once;
    // an idle gap or drain() takes it low.
    task automatic send_item(input row_t row);
        sched_res_t r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        r = predict_schedule(row.cmd, row.id, row.arr, row.need);
        expected_results.push_back(r);
        typed_rows.push_back(row);
        s_valid        <= 1'b1;
        s_command      <= row.cmd;
        s_job_id       <= row.id;
        s_arrival_time <= row.arr;
        s_need_time    <= row.need;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic row_t add_row(input int id, input int arr, input int need);
        row_t row;
        row = '{CMD_ADD, id[7:0], arr[15:0], need[15:0], 1'b0, ST_ADDED, '0};
        return row;
    endfunction

    function automatic row_t tick_row();
        row_t row;
        row = '{CMD_TICK, ID_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                1'b0, ST_IDLE, '0};
        return row;
    endfunction

    // Receiver side with random stalls; the check happens on each transfer.
    always @(posedge aclk) begin
        sched_res_t e;
        row_t tr;
        bit bad;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result status=%0d", m_status);
                end else begin
                    e = expected_results.pop_front();
                    tr = typed_rows.pop_front();
                    bad = (m_status !== e.status) || (m_run_id !== e.run_id) ||
                          (m_tick_time !== e.tick_time) || (m_remaining !== e.remaining);
                    if (tr.has_exp && (m_status !== tr.e_status ||
                                       m_tick_time !== tr.e_time))
                        bad = 1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st=%0d id=%0d t=%0d rem=%0d",
                                      " got st=%0d id=%0d t=%0d rem=%0d"},
                                     e.status, e.run_id, e.tick_time, e.remaining,
                                     m_status, m_run_id, m_tick_time, m_remaining);
                    end
                end
            end
            m_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Random stream: adds, mostly with arrivals near the current time, mixed at random with ticks.
    task automatic random_burst(input int items);
        int n;
        int mode;
        row_t row;
        n = 0;
        while (n < items) begin
            mode = $urandom_range(9);
            if (mode < 4) begin
                row = add_row($urandom, now_time + $urandom_range(0, 12) - 2,
                              $urandom_range(0, 6));
            end else if (mode == 4) begin
                row = add_row($urandom, $urandom, $urandom);
            end else if (mode == 5) begin
                row = add_row($urandom, now_time + $urandom_range(0, 3), $urandom_range(1, 3));
            end else begin
                row = tick_row();
            end
            send_item(row);
            n++;
        end
    endtask

    initial begin
        row_t row;
        now_time = '1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        m_ready <= 1'b1;
        @(posedge aclk);

        // Directed table: first tick after reset is idle at time zero.
        row = tick_row(); row.has_exp = 1; row.e_status = ST_IDLE; row.e_time = 16'd0;
        dir_rows.push_back(row);
        dir_rows.push_back(add_row(8'hFF, 16'h0000, 16'h0000)); // zero need becomes one
        dir_rows.push_back(add_row(8'h00, 16'hFFFF, 16'hFFFF));
        dir_rows.push_back(add_row(8'h5A, 16'h0000, 16'h0003)); // arrival at time zero
        dir_rows.push_back(add_row(8'hA5, 16'h0002, 16'h0001));
        dir_rows.push_back(add_row(8'h11, 16'h0002, 16'h0001)); // equal arrival, equal need
        for (int i = 0; i < 6; i++) dir_rows.push_back(tick_row());
        // One job is still waiting, so fifteen more fill the scheduler.
        for (int i = 0; i < 15; i++) dir_rows.push_back(add_row(i + 1, 16'h0008, 16'h0002));
        row = add_row(8'h77, 16'h0001, 16'h0001); row.has_exp = 1; row.e_status = ST_FULL;
        dir_rows.push_back(row);
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        drain(); // sender pauses until every result has come

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 19 : 78) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 19 : 78) : 0;
            random_burst(ph == 0 ? 700 : 380);
        end
        // A closing run of ticks: the chain holds at most JOBS jobs, so ticks stay cheap.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 20; i++) send_item(tick_row());
        drain();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
